// ===== sv/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, cond)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/crsv_pkg.sv =====
// ----------------------------------------------------------------------------
// crsv_pkg
// types, constants and crc helper for the record stream validator
// ----------------------------------------------------------------------------
package crsv_pkg;

  localparam int OffsetBits = 40;
  localparam int MaxMutations = 65536;
  localparam logic [31:0] CrcPoly = 32'hedb88320;
  localparam logic [31:0] CrcInit = 32'hffffffff;
  localparam logic [31:0] MinPayload = 32'd9;
  localparam logic [4:0] HeaderBytes = 5'd16;

  typedef enum logic [3:0] {
    PH_MAGIC = 4'd0, PH_LEN = 4'd1, PH_PCRC = 4'd2, PH_HCRC = 4'd3,
    PH_COUNT = 4'd4, PH_TAG = 4'd5, PH_KLEN = 4'd6, PH_KEY = 4'd7,
    PH_EXP = 4'd8, PH_VLEN = 4'd9, PH_VAL = 4'd10, PH_TRAIL = 4'd11,
    PH_SKIP = 4'd12, PH_STOP = 4'd13
  } phase_t;

  localparam logic [3:0] CLS_DISCARD = 4'd11;

  localparam logic [3:0] ERR_NONE = 4'd0;
  localparam logic [3:0] ERR_MAGIC = 4'd1;
  localparam logic [3:0] ERR_HEADER = 4'd2;
  localparam logic [3:0] ERR_PCRC = 4'd3;
  localparam logic [3:0] ERR_COUNT = 4'd4;
  localparam logic [3:0] ERR_TAG = 4'd5;
  localparam logic [3:0] ERR_SHORT = 4'd6;
  localparam logic [3:0] ERR_OVERRUN = 4'd7;
  localparam logic [3:0] ERR_EXPIRY = 4'd8;
  localparam logic [3:0] ERR_TRAIL = 4'd9;
  localparam logic [3:0] ERR_TAIL = 4'd10;

  localparam logic [1:0] REG_FILE_LEN = 2'd0;
  localparam logic [1:0] REG_MAX_LEN = 2'd1;

  function automatic logic [31:0] crc_step(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 32'd0);
    end
    return c;
  endfunction

endpackage

// ===== sv/crc_record_stream_validator_unit.sv =====
// ----------------------------------------------------------------------------
// crc_record_stream_validator_unit
// length-prefixed record parser with header and payload crc-32 checks
// ----------------------------------------------------------------------------
// One result per input byte. Each byte is registered, parsed by combinational
// logic (one crc byte step plus field counters and compares) and its result is
// held in an output register; a new byte is taken every cycle whenever the
// output register is empty or being drained, so throughput is one byte per
// clock, and each result passes the input register and then the output register. The
// count-versus-payload limit (count <= left/5) is checked as 5*count <= left.
// After an error or a truncated tail every later byte repeats the stop code.
`include "assert_macros.svh"

module crc_record_stream_validator_unit
  import crsv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // byte_class[3:0], mutation_index[19:4], entry_present[20], record_end[21],
  // record_ok[22], error_code[26:23], parser_stopped[27], record_offset[67:28]
  output logic [71:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [OffsetBits-1:0] file_length_r;
  logic [31:0] max_len_r;

  logic cfg_wr;
  logic [1:0] cfg_idx;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx = cfg_paddr[3] ? REG_MAX_LEN : REG_FILE_LEN;
  // registers sit on 8-byte steps; file length takes the low 40 data bits

  always_comb begin
    unique case (cfg_idx)
      REG_FILE_LEN: cfg_prdata = 64'(file_length_r);
      default:      cfg_prdata = 64'(max_len_r);
    endcase
  end

  // state
  phase_t phase_r, phase_nxt;
  logic [2:0] fbc_r, fbc_nxt;
  logic [OffsetBits-1:0] pos_r, pos_nxt, rstart_r, rstart_nxt;
  logic [31:0] plen_r, plen_nxt, pleft_r, pleft_nxt, hcrc_r, hcrc_nxt;
  logic [31:0] pcrc_r, pcrc_nxt, epcrc_r, epcrc_nxt, sleft_r, sleft_nxt;
  logic [16:0] mtot_r, mtot_nxt, mnum_r, mnum_nxt;
  logic [63:0] shift_r, shift_nxt;
  logic tag_r, tag_nxt, stop_r, stop_nxt;
  logic [3:0] perr_r, perr_nxt;

  // input register
  logic in_v_r;
  logic [7:0] in_b_r;
  logic out_v_r;
  logic [71:0] out_d_r;
  logic proc;

  assign proc = in_v_r & (~out_v_r | out_tready);
  assign in_tready = ~in_v_r | proc;
  assign out_tvalid = out_v_r;
  assign out_tdata = out_d_r;

  // result of the current byte
  logic [3:0] cls, ecode;
  logic [15:0] idx;
  logic present, rend, rok;

  function automatic logic [7:0] magic_byte(input logic [1:0] i);
    unique case (i)
      2'd0: return 8'h46;
      2'd1: return 8'h44;
      2'd2: return 8'h42;
      default: return 8'h31;
    endcase
  endfunction

  always_comb begin
    logic [7:0] b;
    logic [63:0] sh;
    logic [2:0] fc;
    logic done4, done8;
    logic [31:0] v, hc;
    logic [OffsetBits-1:0] avail, remain;
    logic [34:0] cnt5;
    logic go;
    phase_t ph;
    b = in_b_r;
    hc = '0; avail = '0; cnt5 = '0;
    phase_nxt = phase_r; fbc_nxt = fbc_r; rstart_nxt = rstart_r;
    plen_nxt = plen_r; pleft_nxt = pleft_r; hcrc_nxt = hcrc_r; pcrc_nxt = pcrc_r;
    epcrc_nxt = epcrc_r; sleft_nxt = sleft_r; mtot_nxt = mtot_r; mnum_nxt = mnum_r;
    shift_nxt = shift_r; tag_nxt = tag_r; stop_nxt = stop_r; perr_nxt = perr_r;
    pos_nxt = pos_r + 1'b1;
    cls = CLS_DISCARD; idx = '0; present = 1'b0; rend = 1'b0; rok = 1'b0;
    go = ~stop_r;
    remain = file_length_r - pos_r;
    if (go && phase_r == PH_MAGIC && fbc_r == 3'd0) begin
      rstart_nxt = pos_r;
      if (pos_r >= file_length_r) begin
        go = 1'b0;
      end else if (remain < OffsetBits'(HeaderBytes)) begin
        go = 1'b0;
        perr_nxt = ERR_TAIL; stop_nxt = 1'b1; phase_nxt = PH_STOP;
      end else begin
        hcrc_nxt = CrcInit;
        shift_nxt = '0;
      end
    end
    ph = phase_nxt;
    // shift_in using shift_nxt and current fbc
    sh = shift_nxt | (64'(b) << {fbc_r, 3'b000});
    fc = fbc_r + 3'd1;
    done4 = (fc == 3'd4);
    done8 = (fc == 3'd0);
    v = sh[31:0];
    if (go && ph <= PH_HCRC) begin
      cls = ph;
      hc = (ph < PH_HCRC) ? crc_step(hcrc_nxt, b) : hcrc_nxt;
      hcrc_nxt = hc;
      avail = '0;
      if (file_length_r >= rstart_nxt &&
          file_length_r - rstart_nxt >= OffsetBits'(HeaderBytes))
        avail = file_length_r - rstart_nxt - OffsetBits'(HeaderBytes);
      if (ph == PH_MAGIC) begin
        if (b != magic_byte(fbc_r[1:0])) begin
          perr_nxt = ERR_MAGIC; stop_nxt = 1'b1; phase_nxt = PH_STOP;
        end else if (fc == 3'd4) begin
          phase_nxt = PH_LEN; fbc_nxt = '0; shift_nxt = '0;
        end else begin
          fbc_nxt = fc;
        end
      end else if (!done4) begin
        shift_nxt = sh; fbc_nxt = fc;
      end else begin
        fbc_nxt = '0; shift_nxt = '0;
        if (ph == PH_LEN) begin
          plen_nxt = v; phase_nxt = PH_PCRC;
        end else if (ph == PH_PCRC) begin
          epcrc_nxt = v; phase_nxt = PH_HCRC;
        end else if ((hc ^ CrcInit) != v || plen_r > max_len_r || plen_r < MinPayload) begin
          shift_nxt = sh; perr_nxt = ERR_HEADER; stop_nxt = 1'b1; phase_nxt = PH_STOP;
        end else if (OffsetBits'(plen_r) > avail) begin
          shift_nxt = sh; perr_nxt = ERR_TAIL; stop_nxt = 1'b1; phase_nxt = PH_STOP;
        end else begin
          pleft_nxt = plen_r; pcrc_nxt = CrcInit; perr_nxt = ERR_NONE;
          mtot_nxt = '0; mnum_nxt = '0; tag_nxt = 1'b0; phase_nxt = PH_COUNT;
        end
      end
    end else if (go) begin
      cls = (ph <= PH_VAL) ? ph : CLS_DISCARD;
      idx = mnum_r[15:0];
      pcrc_nxt = crc_step(pcrc_r, b);
      pleft_nxt = pleft_r - 1'b1;
      cnt5 = {3'd0, v} + {1'b0, v, 2'b00};
      unique case (ph)
        PH_COUNT: begin
          if (!done4) begin
            shift_nxt = sh; fbc_nxt = fc;
          end else begin
            fbc_nxt = '0; shift_nxt = sh;
            if (v == 32'd0 || v > 32'(MaxMutations) ||
                cnt5 > {3'd0, pleft_nxt}) begin
              perr_nxt = ERR_COUNT; phase_nxt = PH_SKIP;
            end else begin
              mtot_nxt = v[16:0]; mnum_nxt = '0; phase_nxt = PH_TAG; shift_nxt = '0;
            end
          end
        end
        PH_TAG: begin
          if (b > 8'd1) begin
            perr_nxt = ERR_TAG; phase_nxt = PH_SKIP;
          end else begin
            tag_nxt = b[0]; phase_nxt = PH_KLEN; fbc_nxt = '0; shift_nxt = '0;
          end
        end
        PH_KLEN, PH_VLEN: begin
          if (!done4) begin
            shift_nxt = sh; fbc_nxt = fc;
          end else begin
            fbc_nxt = '0; shift_nxt = sh;
            if (v > pleft_nxt) begin
              perr_nxt = ERR_OVERRUN; phase_nxt = PH_SKIP;
            end else begin
              sleft_nxt = v;
              if (v != 32'd0) phase_nxt = (ph == PH_KLEN) ? PH_KEY : PH_VAL;
              else if (ph == PH_KLEN && tag_r) begin
                phase_nxt = PH_EXP; shift_nxt = '0;
              end else begin
                mnum_nxt = mnum_r + 1'b1;
                if (mnum_r + 1'b1 == mtot_r) phase_nxt = PH_TRAIL;
                else begin
                  phase_nxt = PH_TAG; shift_nxt = '0;
                end
              end
            end
          end
        end
        PH_KEY, PH_VAL: begin
          sleft_nxt = sleft_r - 1'b1;
          if (sleft_nxt == 32'd0) begin
            if (ph == PH_KEY && tag_r) begin
              phase_nxt = PH_EXP; fbc_nxt = '0; shift_nxt = '0;
            end else begin
              mnum_nxt = mnum_r + 1'b1;
              if (mnum_r + 1'b1 == mtot_r) phase_nxt = PH_TRAIL;
              else begin
                phase_nxt = PH_TAG; fbc_nxt = '0; shift_nxt = '0;
              end
            end
          end
        end
        PH_EXP: begin
          shift_nxt = sh; fbc_nxt = fc;
          if (done8) begin
            if (sh[63] && sh != '1) begin
              perr_nxt = ERR_EXPIRY; phase_nxt = PH_SKIP;
            end else begin
              phase_nxt = PH_VLEN; shift_nxt = '0;
            end
          end
        end
        PH_TRAIL: begin
          perr_nxt = ERR_TRAIL; phase_nxt = PH_SKIP;
        end
        default: ;
      endcase
      if (ph == PH_TAG) present = (b == 8'd1);
      else if (ph >= PH_KLEN && ph <= PH_VAL) present = tag_r;
      if (pleft_nxt == 32'd0) begin
        rend = 1'b1;
        if ((pcrc_nxt ^ CrcInit) != epcrc_r) begin
          perr_nxt = ERR_PCRC; stop_nxt = 1'b1; phase_nxt = PH_STOP;
        end else if (perr_nxt != ERR_NONE) begin
          stop_nxt = 1'b1; phase_nxt = PH_STOP;
        end else if (phase_nxt == PH_TAG) begin
          perr_nxt = ERR_TAG; stop_nxt = 1'b1; phase_nxt = PH_STOP;
        end else if (phase_nxt != PH_TRAIL) begin
          perr_nxt = ERR_SHORT; stop_nxt = 1'b1; phase_nxt = PH_STOP;
        end else begin
          rok = 1'b1; phase_nxt = PH_MAGIC; fbc_nxt = '0;
        end
      end
    end
    ecode = stop_nxt ? perr_nxt : ERR_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_length_r <= '0;
      max_len_r <= 32'd16777216;
      phase_r <= PH_MAGIC; fbc_r <= '0; pos_r <= '0; rstart_r <= '0;
      plen_r <= '0; pleft_r <= '0; hcrc_r <= CrcInit; pcrc_r <= CrcInit;
      epcrc_r <= '0; sleft_r <= '0; mtot_r <= '0; mnum_r <= '0;
      shift_r <= '0; tag_r <= 1'b0; stop_r <= 1'b0; perr_r <= '0;
      in_v_r <= 1'b0; out_v_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (cfg_idx == REG_FILE_LEN) file_length_r <= cfg_pwdata[OffsetBits-1:0];
        else max_len_r <= cfg_pwdata[31:0];
      end
      if (in_tready) in_v_r <= in_tvalid;
      if (proc) begin
        phase_r <= phase_nxt; fbc_r <= fbc_nxt; pos_r <= pos_nxt; rstart_r <= rstart_nxt;
        plen_r <= plen_nxt; pleft_r <= pleft_nxt; hcrc_r <= hcrc_nxt; pcrc_r <= pcrc_nxt;
        epcrc_r <= epcrc_nxt; sleft_r <= sleft_nxt; mtot_r <= mtot_nxt; mnum_r <= mnum_nxt;
        shift_r <= shift_nxt; tag_r <= tag_nxt; stop_r <= stop_nxt; perr_r <= perr_nxt;
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) in_b_r <= in_tdata;
    if (proc) out_d_r <= {4'd0, rstart_nxt, stop_nxt, ecode, rok, rend, present, idx, cls};
  end

  `ASSERT_IMPL(a_ok_needs_end, !out_v_r || !out_d_r[22] || out_d_r[21])
  `ASSERT_NEXT(a_stop_sticks, stop_r, stop_r)
  `ASSERT_IMPL(a_err_only_stopped, !out_v_r || out_d_r[27] || out_d_r[26:23] == ERR_NONE)

endmodule

// ===== dv/tb_crc_record_stream_validator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_crc_record_stream_validator_unit
// self-checking bench: well-formed log records with random content, register
// extremes, a discarded run past file end and one randomly chosen stop cause
// ----------------------------------------------------------------------------
module tb_crc_record_stream_validator_unit;
  import crsv_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int HoldCycles = 160;

  localparam int F_NONE = 0;
  localparam int F_MIN9 = 1;
  localparam int F_COUNT = 2;
  localparam int F_TAG = 3;
  localparam int F_OVERRUN = 4;
  localparam int F_EXPIRY = 5;
  localparam int F_TRAIL = 6;
  localparam int F_SHORT = 7;
  localparam int F_MINLEN = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;  // data_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // byte_class, mutation_index, entry_present, record_end, record_ok,
  // error_code, parser_stopped, record_offset
  logic [71:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = 4'd0;
  logic [63:0] cfg_pwdata = 64'd0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  crc_record_stream_validator_unit uut (.*);

  always #1 clk = ~clk;

  function automatic logic [31:0] crc32_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 32'hedb88320) : (c >> 1);
    return c;
  endfunction

  class record_scoreboard;
    logic [39:0] file_len;
    logic [31:0] max_len;
    phase_t      phase;
    logic [2:0]  nbytes;
    logic [39:0] pos, rec_start;
    logic [31:0] pay_len, pay_left, hdr_crc, pay_crc, want_crc, str_left;
    logic [16:0] mut_total, mut_num;
    logic [63:0] shreg;
    logic        tag_set, stopped;
    logic [3:0]  held_err;
    logic [71:0] expected_q[$];
    int          errors;

    function new();
      file_len = '0; max_len = 32'd16777216; phase = PH_MAGIC; nbytes = '0;
      pos = '0; rec_start = '0; pay_len = '0; pay_left = '0;
      hdr_crc = CrcInit; pay_crc = CrcInit; want_crc = '0; str_left = '0;
      mut_total = '0; mut_num = '0; shreg = '0; tag_set = 1'b0;
      stopped = 1'b0; held_err = ERR_NONE; errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [39:0] val);
      if (idx == REG_FILE_LEN) file_len = val;
      else if (idx == REG_MAX_LEN) max_len = val[31:0];
    endfunction

    function void halt(logic [3:0] code);
      held_err = code; stopped = 1'b1; phase = PH_STOP;
    endfunction

    function void open_field(phase_t p);
      phase = p; nbytes = '0; shreg = '0;
    endfunction

    function void hold(logic [3:0] code);
      held_err = code; phase = PH_SKIP;
    endfunction

    function bit take(logic [7:0] b, logic [2:0] len);
      shreg |= 64'(b) << (8 * nbytes);
      nbytes = nbytes + 3'd1;
      if (nbytes == len) begin
        nbytes = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void next_mutation();
      mut_num = mut_num + 17'd1;
      if (mut_num == mut_total) phase = PH_TRAIL;
      else open_field(PH_TAG);
    endfunction

    function void key_done();
      if (tag_set) open_field(PH_EXP);
      else next_mutation();
    endfunction

    function void note_byte(logic [7:0] b);
      logic [39:0] p, avail;
      logic [3:0]  cls;
      logic [15:0] idx;
      logic        pres, rend, rok, done;
      phase_t      cur;
      logic [31:0] v;
      logic [7:0]  mb;
      logic [71:0] e;
      p = pos; cls = CLS_DISCARD; idx = '0; pres = 0; rend = 0; rok = 0;
      pos = pos + 40'd1;
      done = stopped;
      if (!done && phase == PH_MAGIC && nbytes == 0) begin
        rec_start = p;
        if (p >= file_len) done = 1;
        else if (file_len - p < 40'd16) begin
          halt(ERR_TAIL); done = 1;
        end else begin
          hdr_crc = CrcInit; shreg = '0;
        end
      end
      if (!done) begin
        cur = phase;
        if (cur <= PH_HCRC) begin
          cls = cur;
          if (cur < PH_HCRC) hdr_crc = crc32_byte(hdr_crc, b);
          if (cur == PH_MAGIC) begin
            case (nbytes[1:0])
              2'd0: mb = 8'h46;
              2'd1: mb = 8'h44;
              2'd2: mb = 8'h42;
              default: mb = 8'h31;
            endcase
            if (b != mb) halt(ERR_MAGIC);
            else begin
              nbytes = nbytes + 3'd1;
              if (nbytes == 3'd4) open_field(PH_LEN);
            end
          end else if (take(b, 3'd4)) begin
            v = shreg[31:0];
            if (cur == PH_LEN) begin
              pay_len = v; open_field(PH_PCRC);
            end else if (cur == PH_PCRC) begin
              want_crc = v; open_field(PH_HCRC);
            end else begin
              avail = '0;
              if (file_len >= rec_start && file_len - rec_start >= 40'd16)
                avail = file_len - rec_start - 40'd16;
              if ((hdr_crc ^ CrcInit) != v || pay_len > max_len || pay_len < MinPayload)
                halt(ERR_HEADER);
              else if (40'(pay_len) > avail) halt(ERR_TAIL);
              else begin
                pay_left = pay_len; pay_crc = CrcInit; held_err = ERR_NONE;
                mut_total = '0; mut_num = '0; tag_set = 0;
                open_field(PH_COUNT);
              end
            end
          end
        end else begin
          cls = (cur <= PH_VAL) ? cur : CLS_DISCARD;
          idx = mut_num[15:0];
          pay_crc = crc32_byte(pay_crc, b);
          pay_left = pay_left - 32'd1;
          case (cur)
            PH_COUNT: if (take(b, 3'd4)) begin
              v = shreg[31:0];
              if (v == 0 || v > MaxMutations || v > pay_left / 5) hold(ERR_COUNT);
              else begin
                mut_total = v[16:0]; mut_num = '0; open_field(PH_TAG);
              end
            end
            PH_TAG: if (b > 8'd1) hold(ERR_TAG);
            else begin
              tag_set = b[0]; open_field(PH_KLEN);
            end
            PH_KLEN, PH_VLEN: if (take(b, 3'd4)) begin
              v = shreg[31:0];
              if (v > pay_left) hold(ERR_OVERRUN);
              else begin
                str_left = v;
                if (cur == PH_KLEN) begin
                  if (v == 0) key_done(); else phase = PH_KEY;
                end else begin
                  if (v == 0) next_mutation(); else phase = PH_VAL;
                end
              end
            end
            PH_KEY: begin
              str_left = str_left - 32'd1;
              if (str_left == 0) key_done();
            end
            PH_VAL: begin
              str_left = str_left - 32'd1;
              if (str_left == 0) next_mutation();
            end
            PH_EXP: if (take(b, 3'd0)) begin
              if (shreg[63] && shreg != '1) hold(ERR_EXPIRY);
              else open_field(PH_VLEN);
            end
            PH_TRAIL: hold(ERR_TRAIL);
            default: ;
          endcase
          if (cur == PH_TAG) pres = (b == 8'd1);
          else if (cur >= PH_KLEN && cur <= PH_VAL) pres = tag_set;
          if (pay_left == 0) begin
            rend = 1;
            if ((pay_crc ^ CrcInit) != want_crc) halt(ERR_PCRC);
            else if (held_err != ERR_NONE) halt(held_err);
            else if (phase == PH_TAG) halt(ERR_TAG);
            else if (phase != PH_TRAIL) halt(ERR_SHORT);
            else begin
              rok = 1; phase = PH_MAGIC; nbytes = '0;
            end
          end
        end
      end
      e = '0;
      e[3:0] = cls; e[19:4] = idx; e[20] = pres; e[21] = rend; e[22] = rok;
      e[26:23] = stopped ? held_err : ERR_NONE; e[27] = stopped; e[67:28] = rec_start;
      expected_q = {expected_q, e};
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [71:0] a);
      logic [71:0] e;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %0h", a);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare("byte_class", e[3:0], a[3:0]);
      compare("mutation_index", e[19:4], a[19:4]);
      compare("entry_present", e[20], a[20]);
      compare("record_end", e[21], a[21]);
      compare("record_ok", e[22], a[22]);
      compare("error_code", e[26:23], a[26:23]);
      compare("parser_stopped", e[27], a[27]);
      compare("record_offset", e[67:28], a[67:28]);
    endfunction
  endclass

  record_scoreboard sb = new();
  logic [7:0] rec[$];
  int cyc = 0;
  int quiet = 0;
  bit squeeze = 0;
  bit squeezed = 0;
  bit calm;

  assign calm = (cyc >= 2000 && cyc < 2600);

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready))) quiet <= 0;
    else if (rst_n) quiet <= quiet + 1;
    if (rst_n && quiet > WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // receiver: random stalls, a calm stretch, and one long hold-off on request
  initial begin
    @(posedge clk);
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (squeeze) begin
        out_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        squeeze = 0;
        out_tready <= 1'b1;
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  task automatic send_byte(logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < 25) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b);
  endtask

  task automatic send_record();
    foreach (rec[i]) send_byte(rec[i]);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx[0], 3'b000}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    sb.set_reg(idx, val[39:0]);
  endtask

  task automatic push_le(ref logic [7:0] q[$], input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) q.insert(q.size(), v[8*i +: 8]);
  endtask

  // builds one record into rec; fault picks a payload defect or shape
  task automatic build_record(int fault);
    logic [7:0]  pay[$];
    logic [31:0] c;
    logic [63:0] ex;
    int n, klen, vlen, tag;
    pay = {};
    n = (fault == F_MIN9) ? 1 : $urandom_range(1, 4);
    if (fault == F_COUNT) push_le(pay, $urandom_range(0, 1) ? 0 : 70000, 4);
    else push_le(pay, n, 4);
    for (int m = 0; m < n; m++) begin
      tag = (fault == F_MIN9) ? 0 : $urandom_range(0, 1);
      if (fault == F_TAG && m == n - 1) begin
        push_le(pay, 64'($urandom_range(2, 255)), 1);
        repeat ($urandom_range(0, 5)) push_le(pay, 64'($urandom), 1);
        break;
      end
      push_le(pay, 64'(tag), 1);
      klen = (fault == F_MIN9) ? 0 : $urandom_range(0, 6);
      if (fault == F_OVERRUN && m == n - 1) begin
        push_le(pay, 32'h0001_0000 | $urandom, 4);
        repeat ($urandom_range(0, 5)) push_le(pay, 64'($urandom), 1);
        break;
      end
      push_le(pay, klen, 4);
      repeat (klen) push_le(pay, 64'($urandom), 1);
      if (tag) begin
        ex = {$urandom, $urandom};
        if (fault == F_EXPIRY && m == n - 1) begin
          ex[63] = 1'b1; ex[0] = 1'b0;
        end else if ($urandom_range(0, 7) == 0) ex = '1;
        else ex[63] = 1'b0;
        push_le(pay, ex, 8);
        vlen = $urandom_range(0, 6);
        push_le(pay, vlen, 4);
        repeat (vlen) push_le(pay, 64'($urandom), 1);
      end
    end
    if (fault == F_TRAIL) repeat ($urandom_range(1, 3)) push_le(pay, 64'($urandom), 1);
    if (fault == F_SHORT) repeat ($urandom_range(1, 3)) void'(pay.pop_back());
    if (fault == F_MINLEN) while (pay.size() > 8) void'(pay.pop_back());
    rec = {8'h46, 8'h44, 8'h42, 8'h31};
    push_le(rec, pay.size(), 4);
    c = CrcInit;
    foreach (pay[i]) c = crc32_byte(c, pay[i]);
    push_le(rec, c ^ CrcInit, 4);
    c = CrcInit;
    foreach (rec[i]) c = crc32_byte(c, rec[i]);
    push_le(rec, c ^ CrcInit, 4);
    rec = {rec, pay};
  endtask

  initial begin
    int kind;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: register extremes, smallest record, two random records
    write_reg(REG_FILE_LEN, 64'hFF_FFFF_FFFF);
    write_reg(REG_MAX_LEN, 64'd9);
    build_record(F_MIN9);
    send_record();
    settle();
    write_reg(REG_MAX_LEN, 64'hFFFF_FFFF);
    repeat (2) begin
      build_record(F_NONE);
      send_record();
    end
    settle();

    // random well-formed records
    write_reg(REG_MAX_LEN, 64'd16777216);
    while (sb.pos < 1250) begin
      if (sb.pos > 300 && !squeezed) begin
        squeeze = 1;
        squeezed = 1;
      end
      if ($urandom_range(0, 15) == 0) begin
        settle();
        write_reg(REG_MAX_LEN, 64'($urandom_range(200, 32'hFFFF_FFFF)));
      end
      build_record(F_NONE);
      send_record();
    end
    settle();

    // bytes at a record start past file end are dropped without stopping
    write_reg(REG_FILE_LEN, 64'd0);
    repeat (6) send_byte(8'($urandom));
    settle();
    write_reg(REG_FILE_LEN, 64'hFFFF_FFFF);
    write_reg(REG_MAX_LEN, 64'd16777216);
    build_record(F_NONE);
    send_record();
    settle();

    // one stop cause per run, then bytes after the stop
    kind = $urandom_range(0, 12);
    case (kind)
      0: begin
        build_record(F_NONE);
        rec[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
      end
      1: begin
        build_record(F_NONE);
        rec[12] ^= 8'h01;
      end
      2: begin
        write_reg(REG_MAX_LEN, 64'd9);
        build_record(F_COUNT);
      end
      3: build_record(F_MINLEN);
      4: begin
        build_record(F_NONE);
        rec[$urandom_range(16, rec.size() - 1)] ^= 8'h80;
      end
      5: build_record(F_COUNT);
      6: build_record(F_TAG);
      7: build_record(F_SHORT);
      8: build_record(F_OVERRUN);
      9: build_record(F_EXPIRY);
      10: build_record(F_TRAIL);
      11: begin
        build_record(F_NONE);
        write_reg(REG_FILE_LEN, 64'(sb.pos) + 64'(rec.size()) - 64'd1);
      end
      default: begin
        build_record(F_NONE);
        write_reg(REG_FILE_LEN, 64'(sb.pos) + 64'($urandom_range(1, 15)));
      end
    endcase
    send_record();
    repeat (20) send_byte(8'($urandom));
    settle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/crsv_pkg.sv
sv/crc_record_stream_validator_unit.sv
dv/tb_crc_record_stream_validator_unit.sv
